FILE: rtl/assert_macros.svh
// assertion macros used by the swap slot table controller
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every clock edge outside reset
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// implication checked in the cycle after the trigger
`define ASSERT_NEXT(lbl, clk, rst_n, trig, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (prop)) \
        else $error(msg);

`endif

FILE: rtl/sst_pkg.sv
// constants and types of the swap slot table
package sst_pkg;

    localparam int TABLE_ENTRIES    = 1024;
    localparam int PAGE_NUMBER_BITS = 36;
    localparam int PAGE_BYTES       = 4096;

    localparam int PAGE_PORT_W = 36;
    localparam int STATUS_W    = 3;
    localparam int SLOT_W      = 10;
    localparam int OFFSET_W    = 22;

    localparam int IDX_W     = $clog2(TABLE_ENTRIES);
    localparam int CNT_W     = $clog2(TABLE_ENTRIES + 1);
    localparam int OFF_SHIFT = $clog2(PAGE_BYTES);

    typedef logic [STATUS_W-1:0]         t_status;
    typedef logic [IDX_W-1:0]            t_idx;
    typedef logic [CNT_W-1:0]            t_cnt;
    typedef logic [PAGE_NUMBER_BITS-1:0] t_page;

    localparam t_status ST_SKIPPED   = 3'd0;
    localparam t_status ST_STORED    = 3'd1;
    localparam t_status ST_FULL      = 3'd2;
    localparam t_status ST_FOUND     = 3'd3;
    localparam t_status ST_NOT_FOUND = 3'd4;

    localparam logic FUNC_EVICT  = 1'b0;
    localparam logic FUNC_LOOKUP = 1'b1;

    typedef struct packed {
        logic  rd_en;
        t_idx  rd_addr;
        logic  wr_en;
        t_idx  wr_addr;
        t_page wr_data;
    } t_mem_req;

    typedef struct packed {
        logic    valid;
        t_status status;
        t_idx    idx;
    } t_result;

endpackage

FILE: rtl/swap_slot_table_unit.sv
// Swap slot table: evict and lookup of page numbers over a table of swap slots.
// A transfer is taken when start is high and busy is low. Slots fill from zero
// upward and are never freed, so the page store holds a filled prefix tracked by
// a fill count and needs no clearing after reset. A read-only evict, or any
// request on an empty table, is answered without a scan; otherwise the request
// scans the filled entries through the single read port of the page store, one
// entry a cycle, and stops at the first match or after the last filled entry.
// The result shows on the result ports for one cycle with o_result_strobe, in
// the cycle after the request is taken when there is no scan, else in the cycle
// in which busy falls; it cannot be held off, so it must be taken in that cycle.
module swap_slot_table_unit (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic                            i_func,
    input  logic [sst_pkg::PAGE_PORT_W-1:0] i_page_number,
    input  logic                            i_page_writable,
    output logic                            o_result_strobe,
    output logic [sst_pkg::STATUS_W-1:0]    o_status,
    output logic [sst_pkg::SLOT_W-1:0]      o_slot,
    output logic [sst_pkg::OFFSET_W-1:0]    o_slot_offset
);

    sst_pkg::t_mem_req mem_req;
    sst_pkg::t_page    rd_data;
    sst_pkg::t_result  result;

    logic [sst_pkg::IDX_W+sst_pkg::OFF_SHIFT-1:0] byte_offset;

    logic                         r_strobe;
    sst_pkg::t_status             r_status;
    logic [sst_pkg::SLOT_W-1:0]   r_slot;
    logic [sst_pkg::OFFSET_W-1:0] r_offset;

    sst_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (start),
        .i_func     (i_func),
        .i_page     (i_page_number[sst_pkg::PAGE_NUMBER_BITS-1:0]),
        .i_writable (i_page_writable),
        .o_busy     (busy),
        .o_mem      (mem_req),
        .i_rd_data  (rd_data),
        .o_result   (result)
    );

    sst_ram #(
        .DEPTH  (sst_pkg::TABLE_ENTRIES),
        .WIDTH  (sst_pkg::PAGE_NUMBER_BITS),
        .ADDR_W (sst_pkg::IDX_W)
    ) u_page_ram (
        .i_clk     (i_clk),
        .i_wr_en   (mem_req.wr_en),
        .i_wr_addr (mem_req.wr_addr),
        .i_wr_data (mem_req.wr_data),
        .i_rd_en   (mem_req.rd_en),
        .i_rd_addr (mem_req.rd_addr),
        .o_rd_data (rd_data)
    );

    assign byte_offset = {result.idx, {sst_pkg::OFF_SHIFT{1'b0}}};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= result.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (result.valid) begin
            r_status <= result.status;
            r_slot   <= sst_pkg::SLOT_W'(result.idx);
            r_offset <= sst_pkg::OFFSET_W'(byte_offset);
        end
    end

    assign o_result_strobe = r_strobe;
    assign o_status        = r_status;
    assign o_slot          = r_slot;
    assign o_slot_offset   = r_offset;

endmodule

FILE: rtl/sst_ram.sv
// simple dual port synchronous ram, registered read data
module sst_ram #(
    parameter int DEPTH  = 1024,
    parameter int WIDTH  = 36,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_wr_en,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]  i_wr_data,
    input  logic              i_rd_en,
    input  logic [ADDR_W-1:0] i_rd_addr,
    output logic [WIDTH-1:0]  o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

FILE: rtl/sst_ctrl.sv
// scan sequencer: fill count, entry scan, page compare and slot allocation
`include "assert_macros.svh"

module sst_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic               i_func,
    input  sst_pkg::t_page     i_page,
    input  logic               i_writable,
    output logic               o_busy,
    output sst_pkg::t_mem_req  o_mem,
    input  sst_pkg::t_page     i_rd_data,
    output sst_pkg::t_result   o_result
);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_SCAN = 1'b1;

    localparam sst_pkg::t_cnt FULL_CNT = sst_pkg::CNT_W'(sst_pkg::TABLE_ENTRIES);

    logic           r_state, n_state;
    sst_pkg::t_idx  r_idx,   n_idx;
    sst_pkg::t_cnt  r_fill,  n_fill;
    sst_pkg::t_page r_page,  n_page;
    logic           r_func,  n_func;

    logic           last_entry;

    assign last_entry = ((sst_pkg::CNT_W'(r_idx) + sst_pkg::CNT_W'(1)) == r_fill);

    always_comb begin
        n_state  = r_state;
        n_idx    = r_idx;
        n_fill   = r_fill;
        n_page   = r_page;
        n_func   = r_func;
        o_mem    = '0;
        o_result = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_page = i_page;
                    n_func = i_func;
                    if (i_func == sst_pkg::FUNC_EVICT && !i_writable) begin
                        o_result.valid  = 1'b1;
                        o_result.status = sst_pkg::ST_SKIPPED;
                    end else if (r_fill == '0) begin
                        o_result.valid = 1'b1;
                        if (i_func == sst_pkg::FUNC_LOOKUP) begin
                            o_result.status = sst_pkg::ST_NOT_FOUND;
                        end else begin
                            o_mem.wr_en     = 1'b1;
                            o_mem.wr_addr   = '0;
                            o_mem.wr_data   = i_page;
                            n_fill          = sst_pkg::CNT_W'(1);
                            o_result.status = sst_pkg::ST_STORED;
                        end
                    end else begin
                        o_mem.rd_en   = 1'b1;
                        o_mem.rd_addr = '0;
                        n_idx         = '0;
                        n_state       = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                if (i_rd_data == r_page) begin
                    n_state        = S_IDLE;
                    o_result.valid = 1'b1;
                    o_result.idx   = r_idx;
                    o_result.status = (r_func == sst_pkg::FUNC_LOOKUP) ?
                                      sst_pkg::ST_FOUND : sst_pkg::ST_STORED;
                end else if (last_entry) begin
                    n_state        = S_IDLE;
                    o_result.valid = 1'b1;
                    if (r_func == sst_pkg::FUNC_LOOKUP) begin
                        o_result.status = sst_pkg::ST_NOT_FOUND;
                    end else if (r_fill == FULL_CNT) begin
                        o_result.status = sst_pkg::ST_FULL;
                    end else begin
                        o_mem.wr_en     = 1'b1;
                        o_mem.wr_addr   = r_fill[sst_pkg::IDX_W-1:0];
                        o_mem.wr_data   = r_page;
                        n_fill          = r_fill + sst_pkg::CNT_W'(1);
                        o_result.status = sst_pkg::ST_STORED;
                        o_result.idx    = r_fill[sst_pkg::IDX_W-1:0];
                    end
                end else begin
                    o_mem.rd_en   = 1'b1;
                    o_mem.rd_addr = r_idx + sst_pkg::IDX_W'(1);
                    n_idx         = r_idx + sst_pkg::IDX_W'(1);
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_fill  <= '0;
        end else begin
            r_state <= n_state;
            r_fill  <= n_fill;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx  <= n_idx;
        r_page <= n_page;
        r_func <= n_func;
    end

    assign o_busy = (r_state != S_IDLE);

    // entries fill from slot zero upward and never exceed the table
    `ASSERT_CLK(a_fill_bound, i_clk, i_rst_n, r_fill <= FULL_CNT, "fill count past table size")
    // scan stays inside the filled prefix
    `ASSERT_CLK(a_scan_in_fill, i_clk, i_rst_n,
                (r_state != S_SCAN) || (sst_pkg::CNT_W'(r_idx) < r_fill), "scan past fill count")
    // read and write of the page store never share a cycle
    `ASSERT_CLK(a_no_rw_overlap, i_clk, i_rst_n, !(o_mem.wr_en && o_mem.rd_en),
                "page store read and write overlap")
    // every allocation grows the fill count by one
    `ASSERT_NEXT(a_fill_step, i_clk, i_rst_n, o_mem.wr_en,
                 r_fill == $past(r_fill) + sst_pkg::CNT_W'(1), "fill count not advanced")

endmodule

FILE: bench/swap_slot_table_unit_tb.sv
// testbench of the swap slot table unit: directed and random evict/lookup requests checked against a slot table predictor
`timescale 1ns / 100ps

module swap_slot_table_unit_tb;

    localparam int CLK_PERIOD    = 10;
    localparam int RANDOM_ITEMS  = 550;
    localparam int MAX_GAP       = 14;
    localparam int SETTLE_CYCLES = sst_pkg::TABLE_ENTRIES + 80;
    localparam int CYCLE_LIMIT   = 8_000_000;

    typedef struct {
        sst_pkg::t_status                  status;
        logic [sst_pkg::SLOT_W-1:0]        slot;
        logic [sst_pkg::OFFSET_W-1:0]      slot_offset;
    } t_slot_reply;

    logic                            i_clk = 1'b0;
    logic                            i_rst_n = 1'b0;
    logic                            start = 1'b0;
    logic                            busy;
    logic                            i_func = sst_pkg::FUNC_EVICT;
    logic [sst_pkg::PAGE_PORT_W-1:0] i_page_number = '0;
    logic                            i_page_writable = 1'b0;
    logic                            o_result_strobe;
    logic [sst_pkg::STATUS_W-1:0]    o_status;
    logic [sst_pkg::SLOT_W-1:0]      o_slot;
    logic [sst_pkg::OFFSET_W-1:0]    o_slot_offset;

    bit             slot_used [sst_pkg::TABLE_ENTRIES];
    sst_pkg::t_page slot_page [sst_pkg::TABLE_ENTRIES];
    int             filled_slots = 0;
    t_slot_reply    pending_replies [$];
    int             error_count = 0;
    int             sent_count = 0;
    int             status_seen [8];
    bit             gaps_on = 1'b1;
    int             cycle_count = 0;

    swap_slot_table_unit dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_func          (i_func),
        .i_page_number   (i_page_number),
        .i_page_writable (i_page_writable),
        .o_result_strobe (o_result_strobe),
        .o_status        (o_status),
        .o_slot          (o_slot),
        .o_slot_offset   (o_slot_offset)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // expected reply of one request, updating the slot table as the block would
    function automatic t_slot_reply table_reply(input logic func, input sst_pkg::t_page page,
                                                input logic writable);
        t_slot_reply reply;
        int          pick;
        reply = '{sst_pkg::ST_NOT_FOUND, '0, '0};
        pick = -1;
        if (func == sst_pkg::FUNC_LOOKUP) begin
            for (int i = 0; i < sst_pkg::TABLE_ENTRIES; i++) begin
                if (slot_used[i] && slot_page[i] == page) begin
                    pick = i;
                    break;
                end
            end
            if (pick >= 0)
                reply.status = sst_pkg::ST_FOUND;
        end else if (!writable) begin
            reply.status = sst_pkg::ST_SKIPPED;
        end else begin
            for (int i = 0; i < sst_pkg::TABLE_ENTRIES; i++) begin
                if (slot_used[i] && slot_page[i] == page) begin
                    pick = i;
                    break;
                end
                if (!slot_used[i] && pick < 0)
                    pick = i;
            end
            if (pick < 0) begin
                reply.status = sst_pkg::ST_FULL;
            end else begin
                if (!slot_used[pick])
                    filled_slots++;
                slot_used[pick] = 1'b1;
                slot_page[pick] = page;
                reply.status = sst_pkg::ST_STORED;
            end
        end
        if (pick >= 0 && reply.status != sst_pkg::ST_NOT_FOUND) begin
            reply.slot        = pick[sst_pkg::SLOT_W-1:0];
            reply.slot_offset = sst_pkg::OFFSET_W'(pick * sst_pkg::PAGE_BYTES);
        end
        return reply;
    endfunction

    function automatic sst_pkg::t_page random_page();
        sst_pkg::t_page page;
        page = sst_pkg::t_page'({$urandom, $urandom});
        case ($urandom_range(0, 15))
            0: page = '0;
            1: page = '1;
            2: page = sst_pkg::t_page'(1);
            3: page = sst_pkg::t_page'(1) << (sst_pkg::PAGE_NUMBER_BITS - 1);
            default: ;
        endcase
        return page;
    endfunction

    function automatic sst_pkg::t_page known_page();
        if (filled_slots == 0)
            return random_page();
        return slot_page[$urandom_range(0, filled_slots - 1)];
    endfunction

    // start stays high after a transfer so that a back-to-back request needs no toggle
    task automatic send_request(input logic func, input sst_pkg::t_page page,
                                input logic writable);
        int gap;
        gap = gaps_on ? $urandom_range(0, MAX_GAP) : 0;
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start           <= 1'b1;
        i_func          <= func;
        i_page_number   <= page;
        i_page_writable <= writable;
        do @(posedge i_clk); while (busy !== 1'b0);
        pending_replies.push_back(table_reply(func, page, writable));
        sent_count++;
    endtask

    always @(posedge i_clk) begin
        t_slot_reply want;
        if (i_rst_n && o_result_strobe) begin
            if (pending_replies.size() == 0) begin
                $error("result with no request outstanding: status %0d slot %0d", o_status,
                       o_slot);
                error_count++;
            end else begin
                want = pending_replies.pop_front();
                status_seen[want.status]++;
                if (o_status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, o_status);
                    error_count++;
                end
                if (o_slot !== want.slot) begin
                    $error("slot: expected %0d, got %0d", want.slot, o_slot);
                    error_count++;
                end
                if (o_slot_offset !== want.slot_offset) begin
                    $error("slot_offset: expected %0d, got %0d", want.slot_offset,
                           o_slot_offset);
                    error_count++;
                end
            end
        end
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles, %0d replies outstanding", cycle_count,
                 pending_replies.size());
        $display("DONE: errors detected");
        $finish;
    end

    // requests on an empty table, answered without a scan, back to back
    task automatic test_empty_table();
        gaps_on = 1'b0;
        send_request(sst_pkg::FUNC_LOOKUP, '0, 1'b0);
        send_request(sst_pkg::FUNC_LOOKUP, '1, 1'b1);
        send_request(sst_pkg::FUNC_EVICT, '1, 1'b0);
        send_request(sst_pkg::FUNC_LOOKUP, sst_pkg::t_page'(1), 1'b1);
    endtask

    task automatic test_directed_basics();
        gaps_on = 1'b1;
        send_request(sst_pkg::FUNC_EVICT, '0, 1'b1);
        send_request(sst_pkg::FUNC_EVICT, '1, 1'b1);
        send_request(sst_pkg::FUNC_EVICT, '0, 1'b1);
        send_request(sst_pkg::FUNC_LOOKUP, '1, 1'b0);
        send_request(sst_pkg::FUNC_LOOKUP, '0, 1'b1);
        send_request(sst_pkg::FUNC_EVICT, '0, 1'b0);
        send_request(sst_pkg::FUNC_LOOKUP, 36'hA_AAAA_AAAA, 1'b0);
        send_request(sst_pkg::FUNC_EVICT, 36'hA_AAAA_AAAA, 1'b1);
        send_request(sst_pkg::FUNC_EVICT, 36'h5_5555_5555, 1'b1);
        send_request(sst_pkg::FUNC_LOOKUP, 36'h5_5555_5555, 1'b1);
        send_request(sst_pkg::FUNC_LOOKUP, 36'hF_FFFF_FFFE, 1'b0);
        send_request(sst_pkg::FUNC_EVICT,
                     sst_pkg::t_page'(1) << (sst_pkg::PAGE_NUMBER_BITS - 1), 1'b1);
        send_request(sst_pkg::FUNC_LOOKUP, sst_pkg::t_page'(1), 1'b0);
        send_request(sst_pkg::FUNC_LOOKUP,
                     sst_pkg::t_page'(1) << (sst_pkg::PAGE_NUMBER_BITS - 1), 1'b1);
        send_request(sst_pkg::FUNC_EVICT, 36'hA_AAAA_AAAA, 1'b1);
    endtask

    task automatic test_random_mix();
        int             kind;
        int             flip;
        sst_pkg::t_page page;
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % 40 == 0)
                gaps_on = ($urandom_range(0, 3) != 0);
            kind = $urandom_range(0, 99);
            if (kind < 30) begin
                send_request(sst_pkg::FUNC_LOOKUP, known_page(), 1'($urandom_range(0, 1)));
            end else if (kind < 45) begin
                send_request(sst_pkg::FUNC_LOOKUP, random_page(), 1'($urandom_range(0, 1)));
            end else if (kind < 65) begin
                send_request(sst_pkg::FUNC_EVICT, known_page(), 1'b1);
            end else if (kind < 80) begin
                send_request(sst_pkg::FUNC_EVICT, random_page(), 1'b1);
            end else if (kind < 90) begin
                page = $urandom_range(0, 1) ? known_page() : random_page();
                send_request(sst_pkg::FUNC_EVICT, page, 1'b0);
            end else begin
                // page one bit away from a stored one
                page = known_page();
                flip = $urandom_range(0, sst_pkg::PAGE_NUMBER_BITS - 1);
                page[flip] = ~page[flip];
                send_request(1'($urandom_range(0, 1)), page, 1'($urandom_range(0, 1)));
            end
        end
    endtask

    task automatic wait_for_replies();
        start <= 1'b0;
        while (pending_replies.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_empty_table();
        test_directed_basics();
        test_random_mix();
        wait_for_replies();
        $display("covered %0d requests: %0d stored, %0d found, %0d not found", sent_count,
                 status_seen[sst_pkg::ST_STORED], status_seen[sst_pkg::ST_FOUND],
                 status_seen[sst_pkg::ST_NOT_FOUND]);
        $display("plus %0d read-only skips, %0d table-full replies, %0d of %0d slots filled",
                 status_seen[sst_pkg::ST_SKIPPED], status_seen[sst_pkg::ST_FULL],
                 filled_slots, sst_pkg::TABLE_ENTRIES);
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

FILE: files.f
+incdir+rtl
rtl/sst_pkg.sv
rtl/sst_ram.sv
rtl/sst_ctrl.sv
rtl/swap_slot_table_unit.sv
bench/swap_slot_table_unit_tb.sv
